FILE: hw/rtl/smct_pkg.sv
// Shared types, widths and codes for the sparse matrix coordinate table.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package smct_pkg;

  localparam int ENTRIES  = 64;
  localparam int MAX_DIM  = 256;

  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int DIM_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int FUNC_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int RES_W    = 40;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 4;

  // The accumulator holds any sum of ENTRIES values without wrapping.
  localparam int ACC_W    = VALUE_W + IDX_W + 1;
  localparam int SAT_W    = ((ACC_W > RES_W) ? ACC_W : RES_W) + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LAST = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COL_LAST = CFG_IDX_W'(1);

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT  = 3'd0,
    FN_CHANGE  = 3'd1,
    FN_LOOKUP  = 3'd2,
    FN_ROW_SUM = 3'd3,
    FN_COL_SUM = 3'd4
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_EXISTS = 3'd1,
    ST_ABSENT = 3'd2,
    ST_RANGE  = 3'd3,
    ST_FULL   = 3'd4
  } status_t;

  typedef struct packed {
    logic [DIM_W-1:0]   row;
    logic [DIM_W-1:0]   col;
    logic [VALUE_W-1:0] value;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic apply;
    logic out_load;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_last;
  } dp_stat_t;

  localparam logic signed [SAT_W-1:0] RES_MAX_EXT = SAT_W'((64'sd1 <<< (RES_W - 1)) - 64'sd1);
  localparam logic signed [SAT_W-1:0] RES_MIN_EXT = -RES_MAX_EXT - SAT_W'(1);

  function automatic logic [RES_W-1:0] sat_sum(input logic [ACC_W-1:0] acc);
    logic signed [SAT_W-1:0] ext;
    logic signed [SAT_W-1:0] clip;
    ext = {{(SAT_W - ACC_W){acc[ACC_W-1]}}, acc};
    if (ext > RES_MAX_EXT) begin
      clip = RES_MAX_EXT;
    end else if (ext < RES_MIN_EXT) begin
      clip = RES_MIN_EXT;
    end else begin
      clip = ext;
    end
    return clip[RES_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/smct_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds the row, column and value words of the table.
`timescale 1ns / 1ps

module smct_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/smct_ctrl.sv
// Sequencing state machine: accept, scan the table, settle, commit, deliver.
// Depends on smct_pkg for the command and status structs.
`timescale 1ns / 1ps

module smct_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output smct_pkg::dp_cmd_t  cmd,
  input  smct_pkg::dp_stat_t stat
);

  import smct_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_APPLY,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The last read word is compared in this cycle.
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = cmd.out_load | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: hw/rtl/smct_dp.sv
// Datapath: configuration registers, entry table, scan compare and sum, result word.
// Depends on smct_pkg and instantiates smct_ram for the entry words.
`timescale 1ns / 1ps

module smct_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  smct_pkg::dp_cmd_t                      cmd,
  output smct_pkg::dp_stat_t                     stat,
  input  logic                                   cfg_we,
  input  logic [smct_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [smct_pkg::DIM_W-1:0]             cfg_data,
  input  logic [smct_pkg::FUNC_W-1:0]            in_func,
  input  logic [smct_pkg::DIM_W-1:0]             in_row,
  input  logic [smct_pkg::DIM_W-1:0]             in_col,
  input  logic signed [smct_pkg::VALUE_W-1:0]    in_value,
  output logic signed [smct_pkg::RES_W-1:0]      out_result,
  output logic [smct_pkg::STATUS_W-1:0]          out_status,
  output logic [smct_pkg::CNT_W-1:0]             out_stored_count
);

  import smct_pkg::*;

  logic [DIM_W-1:0]   row_last_r, col_last_r;

  logic [FUNC_W-1:0]  func_r;
  logic [DIM_W-1:0]   row_r, col_r;
  logic [VALUE_W-1:0] value_r;
  logic               bad_r;

  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  logic [IDX_W-1:0]   cnt_r;
  logic               cmp_v_r;
  logic [IDX_W-1:0]   cmp_idx_r;

  logic               found_r, free_found_r;
  logic [IDX_W-1:0]   match_idx_r, free_idx_r;
  logic [VALUE_W-1:0] match_val_r;
  logic [ACC_W-1:0]   sum_r;

  logic [RES_W-1:0]   res_r, res_nxt;
  status_t            status_r, status_nxt;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wdata, ram_rdata;

  logic               row_ok, col_ok, bad_in;
  logic               e_valid, row_hit, col_hit, sum_hit;

  smct_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt_r),
    .rdata (ram_rdata)
  );

  // Range check of the incoming word against the configured bounds.
  always_comb begin
    row_ok = (in_row <= row_last_r);
    col_ok = (in_col <= col_last_r);
    unique case (in_func)
      FN_INSERT, FN_CHANGE, FN_LOOKUP: bad_in = !(row_ok && col_ok);
      FN_ROW_SUM:                      bad_in = !row_ok;
      FN_COL_SUM:                      bad_in = !col_ok;
      default:                         bad_in = 1'b0;
    endcase
  end

  assign stat.scan_last = (cnt_r == IDX_W'(ENTRIES - 1));

  assign e_valid = valid_r[cmp_idx_r];
  assign row_hit = (ram_rdata.row == row_r);
  assign col_hit = (ram_rdata.col == col_r);
  assign sum_hit = e_valid && (((func_r == FN_ROW_SUM) && row_hit) ||
                               ((func_r == FN_COL_SUM) && col_hit));

  // Commit: decide the outcome and the table update from the scan results.
  always_comb begin
    res_nxt    = '0;
    status_nxt = ST_OK;
    count_nxt  = count_r;
    valid_nxt  = valid_r;
    ram_we     = 1'b0;
    ram_waddr  = match_idx_r;
    ram_wdata  = '{row: row_r, col: col_r, value: value_r};
    if (bad_r) begin
      status_nxt = ST_RANGE;
    end else begin
      unique case (func_r)
        FN_INSERT: begin
          if (found_r) begin
            status_nxt = ST_EXISTS;
          end else if (!free_found_r) begin
            status_nxt = ST_FULL;
          end else begin
            ram_we                = cmd.apply;
            ram_waddr             = free_idx_r;
            valid_nxt[free_idx_r] = 1'b1;
            count_nxt             = count_r + CNT_W'(1);
          end
        end
        FN_CHANGE: begin
          if (!found_r) begin
            status_nxt = ST_ABSENT;
          end else if (value_r != '0) begin
            ram_we = cmd.apply;
          end else begin
            valid_nxt[match_idx_r] = 1'b0;
            if (count_r != '0) begin
              count_nxt = count_r - CNT_W'(1);
            end
          end
        end
        FN_LOOKUP: begin
          if (!found_r) begin
            status_nxt = ST_ABSENT;
          end else begin
            res_nxt = {{(RES_W - VALUE_W){match_val_r[VALUE_W-1]}}, match_val_r};
          end
        end
        FN_ROW_SUM, FN_COL_SUM: begin
          res_nxt = sat_sum(sum_r);
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_last_r <= DIM_W'(MAX_DIM - 1);
      col_last_r <= DIM_W'(MAX_DIM - 1);
      valid_r    <= '0;
      count_r    <= '0;
      cmp_v_r    <= 1'b0;
      cnt_r      <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_ROW_LAST) begin
          row_last_r <= cfg_data;
        end else if (cfg_index == CFG_COL_LAST) begin
          col_last_r <= cfg_data;
        end
      end
      cmp_v_r <= cmd.scan;
      if (cmd.load) begin
        cnt_r <= '0;
      end else if (cmd.scan) begin
        cnt_r <= cnt_r + IDX_W'(1);
      end
      if (cmd.apply) begin
        valid_r <= valid_nxt;
        count_r <= count_nxt;
      end
    end
  end

  // Payload and scan bookkeeping; no reset needed.
  always_ff @(posedge clk) begin
    cmp_idx_r <= cnt_r;
    if (cmd.load) begin
      func_r       <= in_func;
      row_r        <= in_row;
      col_r        <= in_col;
      value_r      <= in_value;
      bad_r        <= bad_in;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      sum_r        <= '0;
    end else if (cmp_v_r) begin
      if (e_valid && row_hit && col_hit && !found_r) begin
        found_r     <= 1'b1;
        match_idx_r <= cmp_idx_r;
        match_val_r <= ram_rdata.value;
      end
      if (!e_valid && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= cmp_idx_r;
      end
      if (sum_hit) begin
        sum_r <= sum_r + {{(ACC_W - VALUE_W){ram_rdata.value[VALUE_W-1]}}, ram_rdata.value};
      end
    end
    if (cmd.apply) begin
      res_r    <= res_nxt;
      status_r <= status_nxt;
    end
    if (cmd.out_load) begin
      out_result       <= res_r;
      out_status       <= status_r;
      out_stored_count <= count_r;
    end
  end

endmodule

FILE: hw/rtl/sparse_matrix_coordinate_table.sv
// Sparse matrix coordinate table, a bounded list of (row, column, value) cells with
// insert, change, lookup, row sum and column sum. After the edge that accepts an input
// word, the block reads every table entry through the single read port of the entry
// RAM, compares the last registered read, commits, and fills the output register,
// which waits while a previous result is still stalled. The input is stalled until
// then, so a new word is not taken before the previous one is through. A new word is
// taken once the previous one has reached the output register, even if that result is
// still stalled. Registers row_last and col_last reset to 255; the user must write
// them only while the block is idle, as the block does not enforce this. cfg_ready
// is always high. Values are signed Q16.16, sums are signed Q24.16 and saturate.
// Reset clears the table at once.
`timescale 1ns / 1ps

module sparse_matrix_coordinate_table (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [smct_pkg::FUNC_W-1:0]         in_func,
  input  logic [smct_pkg::DIM_W-1:0]          in_row,
  input  logic [smct_pkg::DIM_W-1:0]          in_col,
  input  logic signed [smct_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [smct_pkg::RES_W-1:0]   out_result,
  output logic [smct_pkg::STATUS_W-1:0]       out_status,
  output logic [smct_pkg::CNT_W-1:0]          out_stored_count,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [smct_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [smct_pkg::DIM_W-1:0]          cfg_data
);

  import smct_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  smct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  smct_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_we           (cfg_valid & cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_func          (in_func),
    .in_row           (in_row),
    .in_col           (in_col),
    .in_value         (in_value),
    .out_result       (out_result),
    .out_status       (out_status),
    .out_stored_count (out_stored_count)
  );

endmodule
